// ===== hdl/palette_texture_resample_assert.svh =====
// Assertion macros for the palette texture resampler.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef PALETTE_TEXTURE_RESAMPLE_ASSERT_SVH
`define PALETTE_TEXTURE_RESAMPLE_ASSERT_SVH
`ifndef SYNTH
`define PTR_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ptr assertion failed");
`define PTR_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("ptr forbidden condition");
`else
`define PTR_ASSERT(label, prop)
`define PTR_ASSERT_NEVER(label, expr)
`endif
`endif

// ===== hdl/ptr_pkg.sv =====
// Shared types and constants of the palette texture resampler.
// No dependencies.
package ptr_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW = 8;
	localparam int SRC_W = 23;
	localparam logic [3:0] MAX_LOG2 = 4'd10;
	localparam logic [31:0] ALPHA_CLEAR_MASK = 32'h00FF_FFFF;

	typedef enum logic [1:0] {
		REQ_PAL_WR = 2'd0,
		REQ_TEX_WR = 2'd1,
		REQ_PIX_RD = 2'd2,
		REQ_NONE   = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		CFG_SRC_WIDTH  = 3'd0,
		CFG_SRC_HEIGHT = 3'd1,
		CFG_DST_WLOG2  = 3'd2,
		CFG_DST_HLOG2  = 3'd3,
		CFG_USE_ALPHA  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [10:0] src_width;
		logic [10:0] src_height;
		logic [3:0]  dst_width_log2;
		logic [3:0]  dst_height_log2;
		logic        use_alpha;
	} cfg_regs_t;

	typedef struct packed {
		logic             range_err;
		logic [SRC_W-1:0] index;
	} src_t;

	typedef struct packed {
		logic       alpha_nz;
		logic [7:0] cidx;
	} texel_t;

endpackage

// ===== hdl/palette_texture_resample.sv =====
// Top level of the palette texture resampler: request sequencer, config
// registers, output register. Depends on ptr_pkg, ptr_addr_unit, both memories.
//
// channel  dir  handshake                    payload
// s_axis   in   s_axis_tvalid/s_axis_tready  tuser req_type, tdata texel/palette data
// m_axis   out  m_axis_tvalid/m_axis_tready  tuser range_error, tdata rgba
// cfg      in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
// Pixel read: 3 address stages, texel read, palette read, result; the palette
// read is skipped when the source address is out of range. Palette/texel write
// or no-op: the request goes on to the result step with no address or read steps.
// Memories are written at the request edge; no clearing pass after reset.
// A result waits in the output register; the next request is taken meanwhile,
// and the sequencer holds in its last step only while that register is full.
`include "palette_texture_resample_assert.svh"
module palette_texture_resample
	import ptr_pkg::*;
#(
	parameter int TEXEL_DEPTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // address, color_word, color_index, alpha_byte
	input  logic [1:0]  s_axis_tuser,  // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // rgba
	output logic        m_axis_tuser,  // range_error
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int TA_W = $clog2(TEXEL_DEPTH);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_AG1  = 7'b0000010,
		ST_AG2  = 7'b0000100,
		ST_AG3  = 7'b0001000,
		ST_TEX  = 7'b0010000,
		ST_PAL  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	state_t      state_q;
	cfg_regs_t   cfg_q;
	logic [15:0] addr_q;
	req_kind_t   kind_q;
	logic        err_q;

	logic        s_acc, out_free;
	req_kind_t   in_kind;
	logic [15:0] in_addr;
	logic [31:0] in_color;
	logic [7:0]  in_cidx, in_alpha;
	logic        pal_we, tex_we, tex_re, pal_re, in_err;
	texel_t      tex_wdata, tex_rdata;
	logic [31:0] pal_rdata, color;
	src_t        src;

	assign in_kind  = req_kind_t'(s_axis_tuser);
	assign in_addr  = s_axis_tdata[15:0];
	assign in_color = s_axis_tdata[47:16];
	assign in_cidx  = s_axis_tdata[55:48];
	assign in_alpha = s_axis_tdata[63:56];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign cfg_ready = 1'b1;

	assign pal_we = s_acc && (in_kind == REQ_PAL_WR) && (32'(in_addr) < PALETTE_DEPTH);
	assign tex_we = s_acc && (in_kind == REQ_TEX_WR) && (32'(in_addr) < TEXEL_DEPTH);
	assign tex_wdata = '{alpha_nz: (in_alpha != 8'd0), cidx: in_cidx};
	assign tex_re = (state_q == ST_TEX) && !src.range_err;
	assign pal_re = (state_q == ST_PAL);

	always_comb begin
		case (in_kind)
			REQ_PAL_WR: in_err = !(32'(in_addr) < PALETTE_DEPTH);
			REQ_TEX_WR: in_err = !(32'(in_addr) < TEXEL_DEPTH);
			default:    in_err = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{src_width: 11'd1, src_height: 11'd1, dst_width_log2: 4'd0,
				dst_height_log2: 4'd0, use_alpha: 1'b0};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_SRC_WIDTH:  cfg_q.src_width <= cfg_data;
				CFG_SRC_HEIGHT: cfg_q.src_height <= cfg_data;
				CFG_DST_WLOG2:  cfg_q.dst_width_log2 <= cfg_data[3:0];
				CFG_DST_HLOG2:  cfg_q.dst_height_log2 <= cfg_data[3:0];
				CFG_USE_ALPHA:  cfg_q.use_alpha <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ptr_addr_unit #(
		.TEXEL_DEPTH(TEXEL_DEPTH)
	) u_addr (
		.clk(clk),
		.address(addr_q),
		.cfg(cfg_q),
		.src(src)
	);

	ptr_texel_mem #(
		.DEPTH(TEXEL_DEPTH),
		.AW(TA_W)
	) u_texel (
		.clk(clk),
		.we(tex_we),
		.waddr(TA_W'(in_addr)),
		.wdata(tex_wdata),
		.re(tex_re),
		.raddr(src.index[TA_W-1:0]),
		.rdata(tex_rdata)
	);

	ptr_palette_mem u_palette (
		.clk(clk),
		.we(pal_we),
		.waddr(in_addr[PAL_AW-1:0]),
		.wdata(in_color),
		.re(pal_re),
		.raddr(tex_rdata.cidx),
		.rdata(pal_rdata)
	);

	assign color = (cfg_q.use_alpha && tex_rdata.alpha_nz) ? pal_rdata
		: (pal_rdata & ALPHA_CLEAR_MASK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (s_acc) state_q <= (in_kind == REQ_PIX_RD) ? ST_AG1 : ST_OUT;
				ST_AG1:  state_q <= ST_AG2;
				ST_AG2:  state_q <= ST_AG3;
				ST_AG3:  state_q <= ST_TEX;
				ST_TEX:  state_q <= src.range_err ? ST_OUT : ST_PAL;
				ST_PAL:  state_q <= ST_OUT;
				ST_OUT:  if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			addr_q <= in_addr;
			kind_q <= in_kind;
			err_q <= in_err;
		end else if (state_q == ST_TEX) begin
			err_q <= src.range_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			m_axis_tdata <= ((kind_q == REQ_PIX_RD) && !err_q) ? color : 32'd0;
			m_axis_tuser <= err_q;
		end
	end

	`PTR_ASSERT(a_rd_enters_agen, (s_acc && in_kind == REQ_PIX_RD) |=> (state_q == ST_AG1))
	`PTR_ASSERT(a_pal_then_out, (state_q == ST_PAL) |=> (state_q == ST_OUT))
	`PTR_ASSERT(a_result_from_out, $rose(m_axis_tvalid) |-> $past(state_q == ST_OUT))
	`PTR_ASSERT_NEVER(a_write_outside_req, (pal_we || tex_we) && (state_q != ST_IDLE))

endmodule

// ===== hdl/ptr_palette_mem.sv =====
// Palette memory, 256 x 32, one write and one registered read port.
// Depends on ptr_pkg.
module ptr_palette_mem
	import ptr_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [PAL_AW-1:0] waddr,
	input  logic [31:0]       wdata,
	input  logic              re,
	input  logic [PAL_AW-1:0] raddr,
	output logic [31:0]       rdata
);

	logic [31:0] mem [PALETTE_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/ptr_texel_mem.sv =====
// Source texel memory: color index plus nonzero-alpha flag per texel.
// Depends on ptr_pkg.
module ptr_texel_mem
	import ptr_pkg::*;
#(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  texel_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output texel_t        rdata
);

	texel_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/ptr_addr_unit.sv =====
// Three-stage source address generator: nearest-neighbor scaling, row flip,
// range checks. Depends on ptr_pkg.
module ptr_addr_unit
	import ptr_pkg::*;
#(
	parameter int TEXEL_DEPTH = 65536
) (
	input  logic        clk,
	input  logic [15:0] address,
	input  cfg_regs_t   cfg,
	output src_t        src
);

	logic [3:0]  wl, hl;
	logic [10:0] tw, th, tw_m1, th_m1;
	logic [9:0]  w, h;
	logic [15:0] row;
	logic [4:0]  area_sh;
	logic        area_err, ident;

	logic [21:0] prod_u_s1, prod_v_s1;
	logic        ident_s1, err_s1;
	logic [15:0] addr_s1;
	logic [3:0]  wl_s1, hl_s1;

	logic [10:0] u, v;
	logic [21:0] vw_s2;
	logic [10:0] u_s2;
	logic        ident_s2, err_s2;
	logic [15:0] addr_s2;

	logic [SRC_W-1:0] sum;

	always_comb begin
		wl = (cfg.dst_width_log2 > MAX_LOG2) ? MAX_LOG2 : cfg.dst_width_log2;
		hl = (cfg.dst_height_log2 > MAX_LOG2) ? MAX_LOG2 : cfg.dst_height_log2;
		tw = 11'd1 << wl;
		th = 11'd1 << hl;
		tw_m1 = tw - 11'd1;
		th_m1 = th - 11'd1;
		w = address[9:0] & tw_m1[9:0];
		row = address >> wl;
		h = th_m1[9:0] - row[9:0];
		area_sh = {1'b0, wl} + {1'b0, hl};
		area_err = (address >> area_sh) != 16'd0;
		ident = (cfg.src_width == tw) && (cfg.src_height == th);
	end

	always_ff @(posedge clk) begin
		prod_u_s1 <= 22'({w, 1'b1}) * 22'(cfg.src_width);
		prod_v_s1 <= 22'({h, 1'b1}) * 22'(cfg.src_height);
		ident_s1 <= ident;
		err_s1 <= area_err;
		addr_s1 <= address;
		wl_s1 <= wl;
		hl_s1 <= hl;
	end

	// product >> (log2 + 1) stays below the source size
	always_comb begin
		u = 11'(prod_u_s1 >> ({1'b0, wl_s1} + 5'd1));
		v = 11'(prod_v_s1 >> ({1'b0, hl_s1} + 5'd1));
	end

	always_ff @(posedge clk) begin
		vw_s2 <= 22'(v) * 22'(cfg.src_width);
		u_s2 <= u;
		ident_s2 <= ident_s1;
		err_s2 <= err_s1;
		addr_s2 <= addr_s1;
	end

	assign sum = ident_s2 ? SRC_W'(addr_s2) : (SRC_W'(vw_s2) + SRC_W'(u_s2));

	always_ff @(posedge clk) begin
		src.index <= sum;
		src.range_err <= err_s2 || (32'(sum) >= TEXEL_DEPTH);
	end

endmodule
